FILE: rtl/frmsq_pkg.sv
// Shared types and constants for the frame RMS envelope and quiet detector.
package frmsq_pkg;

    // Field and state widths
    localparam int ENERGY_W   = 43;
    localparam int POWER_W    = 32;
    localparam int DECAY_W    = 16;
    localparam int RISE_W     = 24;
    localparam int QFRAC_W    = 16;
    localparam int FRAC_SHIFT = 32;
    localparam int DIVIDEND_W = ENERGY_W + FRAC_SHIFT;
    localparam int QUO_W      = 64;

    // Sequencer step counts
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int SQRT_STEPS = QUO_W / 2;
    localparam int STEP_W     = 7;

    // Register port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64881;
    localparam logic [RISE_W-1:0]  RISE_RESET  = 24'd1678;
    localparam logic [QFRAC_W-1:0] QFRAC_RESET = 16'd655;

    typedef enum logic [1:0] {
        REG_DECAY = 2'd0,
        REG_RISE  = 2'd1,
        REG_QFRAC = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DECAY_W-1:0] decay;
        logic [RISE_W-1:0]  rise;
        logic [QFRAC_W-1:0] qfrac;
    } cfg_t;

    // Controller states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_LOAD  = 11'b000_0000_0010,
        ST_DIV   = 11'b000_0000_0100,
        ST_SQLD  = 11'b000_0000_1000,
        ST_SQRT  = 11'b000_0001_0000,
        ST_MULT  = 11'b000_0010_0000,
        ST_UPD   = 11'b000_0100_0000,
        ST_RANGE = 11'b000_1000_0000,
        ST_PROD  = 11'b001_0000_0000,
        ST_TERM  = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    // Datapath commands
    typedef struct packed {
        logic clear;
        logic accum;
        logic div_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic mult;
        logic update;
        logic range;
        logic prod;
        logic term;
        logic out_load;
    } cmd_t;

endpackage

FILE: rtl/frmsq_regs.sv
// Configuration register file on the APB-style port.
module frmsq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frmsq_pkg::ADDR_W-1:0]  paddr,
    input  logic [frmsq_pkg::DATA_W-1:0]  pwdata,
    output logic [frmsq_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output frmsq_pkg::cfg_t               cfg
);

    logic [frmsq_pkg::DECAY_W-1:0] decay_reg;
    logic [frmsq_pkg::RISE_W-1:0]  rise_reg;
    logic [frmsq_pkg::QFRAC_W-1:0] qfrac_reg;
    frmsq_pkg::reg_idx_t           idx;
    logic                          wr_en;

    assign idx    = frmsq_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes; unmapped addresses are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= frmsq_pkg::DECAY_RESET;
            rise_reg  <= frmsq_pkg::RISE_RESET;
            qfrac_reg <= frmsq_pkg::QFRAC_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                frmsq_pkg::REG_DECAY: decay_reg <= pwdata[frmsq_pkg::DECAY_W-1:0];
                frmsq_pkg::REG_RISE:  rise_reg  <= pwdata[frmsq_pkg::RISE_W-1:0];
                frmsq_pkg::REG_QFRAC: qfrac_reg <= pwdata[frmsq_pkg::QFRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            frmsq_pkg::REG_DECAY: prdata = {16'd0, decay_reg};
            frmsq_pkg::REG_RISE:  prdata = {8'd0, rise_reg};
            frmsq_pkg::REG_QFRAC: prdata = {16'd0, qfrac_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.decay = decay_reg;
    assign cfg.rise  = rise_reg;
    assign cfg.qfrac = qfrac_reg;

endmodule

FILE: rtl/frmsq_ctrl.sv
// Sequencer: input/output handshakes and the end-of-frame step schedule.
module frmsq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic              frame_last,
    output logic              out_valid,
    input  logic              out_stall,
    output frmsq_pkg::cmd_t   cmd
);

    frmsq_pkg::state_t            state_reg, state_next;
    logic [frmsq_pkg::STEP_W-1:0] step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         in_take;
    logic                         out_free;

    assign in_stall  = (state_reg != frmsq_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            frmsq_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (mode)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.accum = 1'b1;
                        if (frame_last)
                        begin
                            state_next = frmsq_pkg::ST_LOAD;
                        end
                    end
                end
            end
            frmsq_pkg::ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = frmsq_pkg::STEP_W'(frmsq_pkg::DIV_STEPS - 1);
                state_next   = frmsq_pkg::ST_DIV;
            end
            frmsq_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = frmsq_pkg::ST_SQLD;
                end
            end
            frmsq_pkg::ST_SQLD:
            begin
                cmd.sqrt_load = 1'b1;
                step_next     = frmsq_pkg::STEP_W'(frmsq_pkg::SQRT_STEPS - 1);
                state_next    = frmsq_pkg::ST_SQRT;
            end
            frmsq_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = frmsq_pkg::ST_MULT;
                end
            end
            frmsq_pkg::ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = frmsq_pkg::ST_UPD;
            end
            frmsq_pkg::ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = frmsq_pkg::ST_RANGE;
            end
            frmsq_pkg::ST_RANGE:
            begin
                cmd.range  = 1'b1;
                state_next = frmsq_pkg::ST_PROD;
            end
            frmsq_pkg::ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = frmsq_pkg::ST_TERM;
            end
            frmsq_pkg::ST_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = frmsq_pkg::ST_OUT;
            end
            frmsq_pkg::ST_OUT:
            begin
                // wait for the output word slot to free up
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = frmsq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frmsq_pkg::ST_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frmsq_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/frmsq_dp.sv
// Datapath: energy accumulator, bit-serial divider and root, envelope update.
module frmsq_dp #(
    parameter int MAX_FRAME_SAMPLES = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  frmsq_pkg::cmd_t               cmd,
    input  frmsq_pkg::cfg_t               cfg,
    input  logic signed [15:0]            sample,
    output logic [frmsq_pkg::POWER_W-1:0] frame_power,
    output logic [frmsq_pkg::POWER_W-1:0] envelope_min,
    output logic [frmsq_pkg::POWER_W-1:0] envelope_max,
    output logic                          is_quiet
);

    localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int EW = frmsq_pkg::ENERGY_W;
    localparam int PW = frmsq_pkg::POWER_W;
    localparam int NW = frmsq_pkg::DIVIDEND_W;
    localparam int QW = frmsq_pkg::QUO_W;

    // Frame accumulator and envelope state
    logic [EW-1:0] energy_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] power_reg;
    logic [PW-1:0] floor_reg;
    logic [PW-1:0] ceil_reg;

    // Divider
    logic [NW-1:0] div_num_reg;
    logic [CW-1:0] div_rem_reg;
    logic [CW-1:0] div_den_reg;
    logic [QW-1:0] quo_reg;

    // Square root
    logic [QW-1:0] sq_x_reg;
    logic [PW+1:0] sq_rem_reg;
    logic [PW-1:0] sq_root_reg;

    // Envelope and threshold pipeline
    logic [PW-1:0]     dec_reg;
    logic [PW-1:0]     rise_reg;
    logic              hit_max_reg;
    logic              hit_min_reg;
    logic              neg_reg;
    logic [PW:0]       mag_reg;
    logic [PW+16:0]    tprod_reg;
    logic signed [34:0] term_reg;

    // Output word
    logic [PW-1:0] out_power_reg;
    logic [PW-1:0] out_min_reg;
    logic [PW-1:0] out_max_reg;
    logic          out_quiet_reg;

    // Sample square and saturating add
    logic signed [31:0] sq_full;
    logic [EW:0]        energy_sum;
    logic [EW-1:0]      energy_add;

    assign sq_full    = sample * sample;
    assign energy_sum = {1'b0, energy_reg} + {{(EW-30){1'b0}}, sq_full[30:0]};
    assign energy_add = energy_sum[EW] ? {EW{1'b1}} : energy_sum[EW-1:0];

    // Restoring divide step
    logic [CW:0] div_trial;
    logic [CW:0] div_diff;

    assign div_trial = {div_rem_reg, div_num_reg[NW-1]};
    assign div_diff  = div_trial - {1'b0, div_den_reg};

    // Root step: two radicand bits per step
    logic [PW+3:0] sq_trial;
    logic [PW+3:0] sq_sub;
    logic [PW+3:0] sq_diff;

    assign sq_trial = {sq_rem_reg, sq_x_reg[QW-1:QW-2]};
    assign sq_sub   = {2'b00, sq_root_reg, 2'b01};
    assign sq_diff  = sq_trial - sq_sub;

    // Envelope products
    logic [PW+15:0] dec_prod;
    logic [PW+23:0] rise_prod;
    logic [PW:0]    range_diff;
    logic [PW+16:0] tprod;

    assign dec_prod   = ceil_reg * cfg.decay;
    assign rise_prod  = sq_root_reg * cfg.rise;
    assign range_diff = {1'b0, ceil_reg} - {1'b0, floor_reg};
    assign tprod      = mag_reg * cfg.qfrac;

    // Threshold term, floor rounding for a negative range
    logic [PW+17:0]     tprod_up;
    logic signed [34:0] term_next;
    logic signed [34:0] thresh;

    assign tprod_up = {1'b0, tprod_reg} + (PW+18)'(16'hFFFF);
    assign term_next = neg_reg ? -$signed({1'b0, tprod_up[PW+17:16]})
                               : $signed({2'b00, tprod_reg[PW+16:16]});
    assign thresh   = $signed({3'b000, floor_reg}) + term_reg;

    // Accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.clear || cmd.div_load)
        begin
            energy_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.accum && (count_reg < CW'(MAX_FRAME_SAMPLES)))
        begin
            energy_reg <= energy_add;
            count_reg  <= count_reg + 1'b1;
        end
    end

    // Envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= '0;
            floor_reg <= '0;
            ceil_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            power_reg <= '0;
            floor_reg <= '0;
            ceil_reg  <= '0;
        end
        else if (cmd.mult)
        begin
            power_reg <= sq_root_reg;
        end
        else if (cmd.update)
        begin
            if (hit_max_reg)
            begin
                ceil_reg <= power_reg;
            end
            else if (hit_min_reg)
            begin
                floor_reg <= power_reg;
            end
            else
            begin
                ceil_reg  <= dec_reg;
                floor_reg <= floor_reg + rise_reg;
            end
        end
    end

    // Divider: energy * 2^32 / count, one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_num_reg <= {energy_reg, {frmsq_pkg::FRAC_SHIFT{1'b0}}};
            div_den_reg <= count_reg;
            div_rem_reg <= '0;
            quo_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            div_num_reg <= {div_num_reg[NW-2:0], 1'b0};
            if (!div_diff[CW])
            begin
                div_rem_reg <= div_diff[CW-1:0];
                quo_reg     <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_trial[CW-1:0];
                quo_reg     <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    // Integer square root, one root bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            sq_x_reg    <= quo_reg;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_x_reg <= {sq_x_reg[QW-3:0], 2'b00};
            if (sq_trial >= sq_sub)
            begin
                sq_rem_reg  <= sq_diff[PW+1:0];
                sq_root_reg <= {sq_root_reg[PW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_trial[PW+1:0];
                sq_root_reg <= {sq_root_reg[PW-2:0], 1'b0};
            end
        end
    end

    // Envelope products and threshold pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            dec_reg     <= dec_prod[PW+15:16];
            rise_reg    <= rise_prod[PW+23:24];
            hit_max_reg <= (sq_root_reg >= ceil_reg);
            hit_min_reg <= (sq_root_reg <= floor_reg);
        end
        if (cmd.range)
        begin
            neg_reg <= range_diff[PW];
            mag_reg <= range_diff[PW] ? (~range_diff + 1'b1) : range_diff;
        end
        if (cmd.prod)
        begin
            tprod_reg <= tprod;
        end
        if (cmd.term)
        begin
            term_reg <= term_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_power_reg <= power_reg;
            out_min_reg   <= floor_reg;
            out_max_reg   <= ceil_reg;
            out_quiet_reg <= ($signed({3'b000, power_reg}) < thresh);
        end
    end

    assign frame_power  = out_power_reg;
    assign envelope_min = out_min_reg;
    assign envelope_max = out_max_reg;
    assign is_quiet     = out_quiet_reg;

endmodule

FILE: rtl/frame_rms_envelope_quiet_detect_unit.sv
// Frame RMS power envelope tracker with quiet detection, top level.
// A sample that does not close a frame, and a clear word, are accepted back to back.
// A frame-closing sample holds in_stall high through the load, 75 divider steps,
// the root load, 32 root steps and the MULT, UPD, RANGE, PROD, TERM and OUT states;
// its result word is registered and made valid when OUT finds the output slot free.
// Reset clears the accumulator and envelope, drops out_valid and loads register defaults.
module frame_rms_envelope_quiet_detect_unit #(
    parameter int MAX_FRAME_SAMPLES = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frmsq_pkg::ADDR_W-1:0]  paddr,
    input  logic [frmsq_pkg::DATA_W-1:0]  pwdata,
    output logic [frmsq_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic signed [15:0]            sample,
    input  logic                          frame_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [frmsq_pkg::POWER_W-1:0] frame_power,
    output logic [frmsq_pkg::POWER_W-1:0] envelope_min,
    output logic [frmsq_pkg::POWER_W-1:0] envelope_max,
    output logic                          is_quiet
);

    frmsq_pkg::cfg_t cfg;
    frmsq_pkg::cmd_t cmd;

    frmsq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    frmsq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd)
    );

    frmsq_dp #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .sample       (sample),
        .frame_power  (frame_power),
        .envelope_min (envelope_min),
        .envelope_max (envelope_max),
        .is_quiet     (is_quiet)
    );

endmodule

FILE: rtl/frmsq_checker.sv
// Port-level checks for the frame RMS envelope unit, bound to the top level.
module frmsq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          mode,
    input logic                          frame_last,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [frmsq_pkg::POWER_W-1:0] frame_power,
    input logic [frmsq_pkg::POWER_W-1:0] envelope_min,
    input logic [frmsq_pkg::POWER_W-1:0] envelope_max,
    input logic                          is_quiet
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_power)
            && $stable(envelope_min) && $stable(envelope_max) && $stable(is_quiet))
        else $error("stalled result word changed");

    // A frame-closing sample starts the divide and root sequence
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode && frame_last |=> in_stall)
        else $error("input not stalled after frame close");

    // Clear words and mid-frame samples leave the input free in the next cycle
    a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode || !frame_last) |=> !in_stall)
        else $error("input stalled after single-cycle word");

    // RMS of 16-bit samples never exceeds 2^15 in Q16.16
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_power <= 32'h8000_0000)
        else $error("frame power out of range");

endmodule

bind frame_rms_envelope_quiet_detect_unit frmsq_checker u_frmsq_checker (.*);

FILE: dv/tb_top.sv
// Testbench for the frame RMS envelope and quiet detector: scoreboard, stimulus and checks.
module tb_top;

    localparam int FRAME_CAP   = 8192;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYC  = 120;
    localparam int PHASE_WORDS = 200;

    typedef struct {
        logic [frmsq_pkg::POWER_W-1:0] power;
        logic [frmsq_pkg::POWER_W-1:0] env_lo;
        logic [frmsq_pkg::POWER_W-1:0] env_hi;
        logic                          quiet;
    } frame_stats_t;

    // Envelope scoreboard: tracks accumulator and envelope, queues expected frame stats
    class envelope_scoreboard;
        logic [frmsq_pkg::DECAY_W-1:0]  decay_gain;
        logic [frmsq_pkg::RISE_W-1:0]   rise_gain;
        logic [frmsq_pkg::QFRAC_W-1:0]  quiet_frac;
        logic [frmsq_pkg::ENERGY_W-1:0] energy;
        logic [13:0]                    count;
        logic [frmsq_pkg::POWER_W-1:0]  env_lo;
        logic [frmsq_pkg::POWER_W-1:0]  env_hi;
        frame_stats_t                   expected_q[$];
        int                             fail_count;

        function new();
            decay_gain = frmsq_pkg::DECAY_RESET;
            rise_gain  = frmsq_pkg::RISE_RESET;
            quiet_frac = frmsq_pkg::QFRAC_RESET;
            energy     = '0;
            count      = '0;
            env_lo     = '0;
            env_hi     = '0;
            fail_count = 0;
        endfunction

        function void set_gain(frmsq_pkg::reg_idx_t idx, logic [frmsq_pkg::DATA_W-1:0] val);
            case (idx)
                frmsq_pkg::REG_DECAY: decay_gain = val[frmsq_pkg::DECAY_W-1:0];
                frmsq_pkg::REG_RISE:  rise_gain  = val[frmsq_pkg::RISE_W-1:0];
                frmsq_pkg::REG_QFRAC: quiet_frac = val[frmsq_pkg::QFRAC_W-1:0];
                default: ;
            endcase
        endfunction

        // Floor of the square root, one result bit per pass
        function logic [31:0] root_floor(logic [63:0] x);
            logic [63:0] rest;
            logic [63:0] res;
            logic [63:0] one;
            rest = x;
            res  = '0;
            one  = 64'd1 << 62;
            while (one > rest)
                one = one >> 2;
            while (one != 0)
            begin
                if (rest >= res + one)
                begin
                    rest = rest - (res + one);
                    res  = (res >> 1) + one;
                end
                else
                begin
                    res = res >> 1;
                end
                one = one >> 2;
            end
            return res[31:0];
        endfunction

        // Accepted input word: accumulate, and on frame close predict the stats
        function void note_word(logic m, logic [15:0] s, logic fl);
            logic [43:0]                   mag;
            logic [43:0]                   acc;
            logic [75:0]                   quo;
            logic [63:0]                   prod;
            logic [frmsq_pkg::POWER_W-1:0] p;
            longint                        rng;
            longint                        qf;
            longint                        term;
            longint                        thresh;
            frame_stats_t                  fs;
            if (m)
            begin
                energy = '0;
                count  = '0;
                env_lo = '0;
                env_hi = '0;
                return;
            end
            mag = s[15] ? 44'h10000 - {28'd0, s} : {28'd0, s};
            if (count < FRAME_CAP)
            begin
                acc = {1'b0, energy} + mag * mag;
                energy = acc[43] ? {frmsq_pkg::ENERGY_W{1'b1}} : acc[frmsq_pkg::ENERGY_W-1:0];
                count  = count + 1'b1;
            end
            if (!fl)
                return;

            quo = {1'b0, energy, 32'd0} / {62'd0, count};
            p   = root_floor(quo[63:0]);

            // Envelope: new max, else new min, else decay max and raise min
            if (p >= env_hi)
            begin
                env_hi = p;
            end
            else if (p <= env_lo)
            begin
                env_lo = p;
            end
            else
            begin
                prod   = {32'd0, env_hi} * {48'd0, decay_gain};
                env_hi = prod[47:16];
                prod   = {32'd0, p} * {40'd0, rise_gain};
                env_lo = env_lo + prod[55:24];
            end

            // Quiet threshold, term floored toward minus infinity
            rng    = $signed({32'd0, env_hi}) - $signed({32'd0, env_lo});
            qf     = {48'd0, quiet_frac};
            term   = (rng * qf) >>> 16;
            thresh = $signed({32'd0, env_lo}) + term;

            fs.power  = p;
            fs.env_lo = env_lo;
            fs.env_hi = env_hi;
            fs.quiet  = ($signed({32'd0, p}) < thresh);
            expected_q.push_back(fs);
            energy = '0;
            count  = '0;
        endfunction

        // Accepted result word against the oldest pending frame
        function void compare_frame(logic [frmsq_pkg::POWER_W-1:0] power,
                                    logic [frmsq_pkg::POWER_W-1:0] lo,
                                    logic [frmsq_pkg::POWER_W-1:0] hi, logic quiet);
            frame_stats_t e;
            if (expected_q.size() == 0)
            begin
                $error("result word with no frame pending: frame_power %0d", power);
                fail_count++;
                return;
            end
            e = expected_q.pop_front();
            if (power !== e.power)
            begin
                $error("frame_power mismatch: expected %0d, actual %0d", e.power, power);
                fail_count++;
            end
            if (lo !== e.env_lo)
            begin
                $error("envelope_min mismatch: expected %0d, actual %0d", e.env_lo, lo);
                fail_count++;
            end
            if (hi !== e.env_hi)
            begin
                $error("envelope_max mismatch: expected %0d, actual %0d", e.env_hi, hi);
                fail_count++;
            end
            if (quiet !== e.quiet)
            begin
                $error("is_quiet mismatch: expected %0d, actual %0d", e.quiet, quiet);
                fail_count++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [frmsq_pkg::ADDR_W-1:0]  paddr = '0;
    logic [frmsq_pkg::DATA_W-1:0]  pwdata = '0;
    logic [frmsq_pkg::DATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          mode = 1'b0;
    logic signed [15:0]            sample = '0;
    logic                          frame_last = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [frmsq_pkg::POWER_W-1:0] frame_power;
    logic [frmsq_pkg::POWER_W-1:0] envelope_min;
    logic [frmsq_pkg::POWER_W-1:0] envelope_max;
    logic                          is_quiet;

    int                            send_idle_pct = 0;
    int                            recv_idle_pct = 0;
    int                            quiet_cycles = 0;
    envelope_scoreboard            sb;

    frame_rms_envelope_quiet_detect_unit #(
        .MAX_FRAME_SAMPLES(FRAME_CAP)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .sample       (sample),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_power  (frame_power),
        .envelope_min (envelope_min),
        .envelope_max (envelope_max),
        .is_quiet     (is_quiet)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Random back-pressure on the result side
    always @(negedge clk)
        out_stall = ($urandom_range(99) < recv_idle_pct);

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.compare_frame(frame_power, envelope_min, envelope_max, is_quiet);
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // One input word, with a random gap ahead of it; called and returns at a falling edge
    task automatic send_word(input logic m, input logic [15:0] s, input logic fl);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode       = m;
        sample     = s;
        frame_last = fl;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(m, s, fl);
        @(negedge clk);
    endtask

    // Drain all pending frames, then let the block finish any trailing word
    task automatic settle();
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Register access: setup cycle, then access cycle until pready
    task automatic reg_access(input logic wr, input frmsq_pkg::reg_idx_t idx,
                              input logic [frmsq_pkg::DATA_W-1:0] wdata,
                              output logic [frmsq_pkg::DATA_W-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write all three gains, then read them back
    task automatic write_gains(input logic [frmsq_pkg::DATA_W-1:0] d,
                               input logic [frmsq_pkg::DATA_W-1:0] r,
                               input logic [frmsq_pkg::DATA_W-1:0] q);
        frmsq_pkg::reg_idx_t          regs[3];
        logic [frmsq_pkg::DATA_W-1:0] vals[3];
        logic [frmsq_pkg::DATA_W-1:0] rd;
        regs = '{frmsq_pkg::REG_DECAY, frmsq_pkg::REG_RISE, frmsq_pkg::REG_QFRAC};
        vals = '{d, r, q};
        foreach (regs[i])
        begin
            reg_access(1'b1, regs[i], vals[i], rd);
            sb.set_gain(regs[i], vals[i]);
        end
        foreach (regs[i])
        begin
            reg_access(1'b0, regs[i], '0, rd);
            if (rd !== vals[i])
            begin
                $error("prdata mismatch: expected %0d, actual %0d", vals[i], rd);
                sb.fail_count++;
            end
        end
    endtask

    // Random frames of mixed loudness, with clears and broken frames mixed in
    task automatic run_random(input int n);
        int          sent;
        int          len;
        int          cls;
        logic [15:0] s;
        logic [15:0] hold;
        sent = 0;
        hold = 16'($urandom);
        while (sent < n)
        begin
            if ($urandom_range(99) < 4)
            begin
                send_word(1'b1, 16'($urandom), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
                cls = $urandom_range(4);
                if (cls == 4 && $urandom_range(3) == 0)
                    hold = 16'($urandom);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(199) == 0)
                        send_word(1'b1, 16'($urandom), 1'($urandom_range(1)));
                    case (cls)
                        0:       s = 16'($urandom_range(6) - 3);
                        1:       s = 16'($urandom_range(511) - 256);
                        2:       s = 16'($urandom_range(16383) - 8192);
                        3:       s = 16'($urandom);
                        default: s = hold;
                    endcase
                    send_word(1'b0, s, (i == len - 1));
                end
                sent += len;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 59;

        // Directed: clear ignores its payload, silent stream, full-scale max,
        // decay case, new min, clear in mid-frame
        send_word(1'b1, 16'h8000, 1'b1);
        send_word(1'b0, 16'h0000, 1'b1);
        send_word(1'b0, 16'h0000, 1'b1);
        send_word(1'b0, 16'h7fff, 1'b1);
        send_word(1'b0, 16'h8000, 1'b1);
        send_word(1'b0, 16'h0001, 1'b0);
        send_word(1'b0, 16'hffff, 1'b1);
        send_word(1'b0, 16'h0000, 1'b1);
        send_word(1'b0, 16'd100, 1'b0);
        send_word(1'b0, -16'sd100, 1'b0);
        send_word(1'b0, 16'd100, 1'b1);
        send_word(1'b0, 16'd12345, 1'b0);
        send_word(1'b1, 16'h7fff, 1'b0);
        send_word(1'b0, 16'd5, 1'b1);
        send_word(1'b0, 16'h4000, 1'b0);
        send_word(1'b0, 16'hc000, 1'b1);
        send_word(1'b0, 16'h8000, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph > 0)
            begin
                settle();
                case (ph)
                    1: write_gains(32'hffff, 32'hff_ffff, 32'hffff);
                    2: write_gains(32'h0, 32'h0, 32'h0);
                    4: write_gains(32'h8000, 32'h10_0000, 32'h4000);
                    default: write_gains($urandom_range(16'hffff), $urandom_range(24'hff_ffff),
                                         $urandom_range(16'hffff));
                endcase
            end
            run_random(PHASE_WORDS);
        end

        settle();
        if (sb.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/frmsq_pkg.sv
rtl/frmsq_regs.sv
rtl/frmsq_ctrl.sv
rtl/frmsq_dp.sv
rtl/frame_rms_envelope_quiet_detect_unit.sv
rtl/frmsq_checker.sv
dv/tb_top.sv
